[sv/nsog_pkg.sv]
// Shared types and constants for the nibble seed order generator.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package nsog_pkg;

    localparam int MAX_ALGOS = 16;
    localparam int ALGO_W    = 5;
    localparam int DIGIT_W   = 4;
    localparam int BYTE_W    = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [ALGO_W-1:0] ALGO_RESET = 5'd15;
    localparam logic [ALGO_W-1:0] ALGO_MIN   = 5'd2;
    localparam logic [ALGO_W-1:0] ALGO_MAX   = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_ALGO_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_NIB,
        ST_END,
        ST_FILL,
        ST_FTERM
    } st_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               valid;
        logic               last;
    } res_t;

endpackage

[sv/nsog_apb.sv]
// APB configuration register (algo_count) for the order generator.
// Depends on nsog_pkg.
`timescale 1ns / 1ps

module nsog_apb (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nsog_pkg::APB_AW-1:0]      paddr,
    input  logic [nsog_pkg::APB_DW-1:0]      pwdata,
    output logic [nsog_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output logic [nsog_pkg::ALGO_W-1:0]      algo_count
);

    logic [nsog_pkg::ALGO_W-1:0] algo_count_reg;
    logic [nsog_pkg::ALGO_W-1:0] algo_count_next;
    logic                        wr_en;
    logic                        sel_algo;

    assign pready   = 1'b1;
    assign sel_algo = (paddr[2] == nsog_pkg::REG_ALGO_COUNT);
    assign wr_en    = psel & penable & pwrite & pready;

    always_comb begin
        algo_count_next = algo_count_reg;
        if (wr_en && sel_algo) begin
            algo_count_next = pwdata[nsog_pkg::ALGO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            algo_count_reg <= nsog_pkg::ALGO_RESET;
        end else begin
            algo_count_reg <= algo_count_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_algo) begin
            prdata = {{(nsog_pkg::APB_DW-nsog_pkg::ALGO_W){1'b0}}, algo_count_reg};
        end
    end

    assign algo_count = algo_count_reg;

endmodule

[sv/nsog_alu.sv]
// Shared compare/subtract unit: a >= b and a - b on 5-bit operands.
// Depends on nsog_pkg.
`timescale 1ns / 1ps

module nsog_alu (
    input  logic [nsog_pkg::ALGO_W-1:0] a,
    input  logic [nsog_pkg::ALGO_W-1:0] b,
    output logic                        ge,
    output logic [nsog_pkg::ALGO_W-1:0] diff
);

    assign ge   = (a >= b);
    assign diff = a - b;

endmodule

[sv/nsog_outbuf.sv]
// Result output register with stream handshake.
// Depends on nsog_pkg.
`timescale 1ns / 1ps

module nsog_outbuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  nsog_pkg::res_t        res_in,
    output logic                  slot_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic           vld_reg;
    logic           vld_next;
    nsog_pkg::res_t res_reg;

    assign slot_free = !vld_reg || m_tready;

    always_comb begin
        vld_next = vld_reg;
        if (push) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {{(8-nsog_pkg::DIGIT_W){1'b0}}, res_reg.digit};
    assign m_tuser  = res_reg.valid;
    assign m_tlast  = res_reg.last;

endmodule

[sv/nsog_core.sv]
// Sequencer: nibble reduction, first-seen tracking, terminator and end-of-seed fill.
// Depends on nsog_pkg and nsog_alu.
`timescale 1ns / 1ps

module nsog_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [nsog_pkg::ALGO_W-1:0]       algo_count,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [nsog_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              in_last,
    input  logic                              slot_free,
    output logic                              push,
    output nsog_pkg::res_t                    res
);

    localparam int M = nsog_pkg::MAX_ALGOS;

    nsog_pkg::st_t                   state_reg, state_next;
    logic [nsog_pkg::BYTE_W-1:0]     byte_reg, byte_next;
    logic                            last_reg, last_next;
    logic                            lo_sel_reg, lo_sel_next;
    logic [nsog_pkg::DIGIT_W-1:0]    rem_reg, rem_next;
    logic [M-1:0]                    mask_reg, mask_next;
    logic [nsog_pkg::ALGO_W-1:0]     count_reg, count_next;
    logic                            complete_reg, complete_next;
    logic [nsog_pkg::DIGIT_W-1:0]    idx_reg, idx_next;

    logic [nsog_pkg::ALGO_W-1:0]     n_eff;
    logic [nsog_pkg::ALGO_W-1:0]     count_inc;
    logic [M-1:0]                    below_n;
    logic [M-1:0]                    missing;
    logic [M-1:0]                    missing_hi;
    logic                            fill_last;
    logic                            new_val;
    logic [nsog_pkg::ALGO_W-1:0]     alu_a;
    logic                            alu_ge;
    logic [nsog_pkg::ALGO_W-1:0]     alu_diff;

    nsog_pkg::res_t                  term_res;

    always_comb begin
        n_eff = algo_count;
        if (algo_count < nsog_pkg::ALGO_MIN) begin
            n_eff = nsog_pkg::ALGO_MIN;
        end else if (algo_count > nsog_pkg::ALGO_MAX) begin
            n_eff = nsog_pkg::ALGO_MAX;
        end
    end

    always_comb begin
        for (int j = 0; j < M; j++) begin
            below_n[j] = (nsog_pkg::ALGO_W'(j) < n_eff);
        end
    end

    assign missing    = ~mask_reg & below_n;
    assign missing_hi = missing >> idx_reg;
    assign fill_last  = (missing_hi == M'(1));
    assign count_inc  = count_reg + nsog_pkg::ALGO_W'(1);
    assign new_val    = !complete_reg && !mask_reg[rem_reg];

    assign term_res = '{digit: '0, valid: 1'b0, last: 1'b1};

    nsog_alu u_alu (
        .a    (alu_a),
        .b    (n_eff),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= nsog_pkg::ST_IDLE;
            mask_reg     <= '0;
            count_reg    <= '0;
            complete_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            count_reg    <= count_next;
            complete_reg <= complete_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        lo_sel_reg <= lo_sel_next;
        rem_reg    <= rem_next;
        idx_reg    <= idx_next;
    end

    always_comb begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        lo_sel_next   = lo_sel_reg;
        rem_next      = rem_reg;
        mask_next     = mask_reg;
        count_next    = count_reg;
        complete_next = complete_reg;
        idx_next      = idx_reg;
        in_ready      = 1'b0;
        push          = 1'b0;
        res           = term_res;
        alu_a         = count_reg;

        unique case (state_reg)
            nsog_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    byte_next   = in_byte;
                    last_next   = in_last;
                    lo_sel_next = 1'b0;
                    state_next  = nsog_pkg::ST_CHECK;
                end
            end
            nsog_pkg::ST_CHECK: begin
                // count already at or past the modulus: order closes at once
                alu_a = count_reg;
                if (!complete_reg && alu_ge) begin
                    if (slot_free) begin
                        push          = 1'b1;
                        complete_next = 1'b1;
                        rem_next      = byte_reg[7:4];
                        state_next    = nsog_pkg::ST_MOD;
                    end
                end else begin
                    rem_next   = byte_reg[7:4];
                    state_next = nsog_pkg::ST_MOD;
                end
            end
            nsog_pkg::ST_MOD: begin
                alu_a = {1'b0, rem_reg};
                if (alu_ge) begin
                    rem_next = alu_diff[nsog_pkg::DIGIT_W-1:0];
                end else begin
                    state_next = nsog_pkg::ST_NIB;
                end
            end
            nsog_pkg::ST_NIB: begin
                alu_a = count_inc;
                if (!new_val || slot_free) begin
                    if (new_val) begin
                        push                = 1'b1;
                        mask_next[rem_reg]  = 1'b1;
                        count_next          = count_inc;
                        if (alu_ge) begin
                            complete_next = 1'b1;
                        end else begin
                            res = '{digit: rem_reg, valid: 1'b1, last: 1'b0};
                        end
                    end
                    if (!lo_sel_reg) begin
                        lo_sel_next = 1'b1;
                        rem_next    = byte_reg[3:0];
                        state_next  = nsog_pkg::ST_MOD;
                    end else begin
                        state_next = nsog_pkg::ST_END;
                    end
                end
            end
            nsog_pkg::ST_END: begin
                idx_next = '0;
                if (!last_reg) begin
                    state_next = nsog_pkg::ST_IDLE;
                end else if (complete_reg) begin
                    mask_next     = '0;
                    count_next    = '0;
                    complete_next = 1'b0;
                    state_next    = nsog_pkg::ST_IDLE;
                end else if (missing == '0) begin
                    state_next = nsog_pkg::ST_FTERM;
                end else begin
                    state_next = nsog_pkg::ST_FILL;
                end
            end
            nsog_pkg::ST_FILL: begin
                if (!missing[idx_reg]) begin
                    idx_next = idx_reg + nsog_pkg::DIGIT_W'(1);
                end else if (slot_free) begin
                    push = 1'b1;
                    res  = '{digit: idx_reg, valid: 1'b1, last: fill_last};
                    if (fill_last) begin
                        mask_next     = '0;
                        count_next    = '0;
                        complete_next = 1'b0;
                        state_next    = nsog_pkg::ST_IDLE;
                    end else begin
                        idx_next = idx_reg + nsog_pkg::DIGIT_W'(1);
                    end
                end
            end
            nsog_pkg::ST_FTERM: begin
                if (slot_free) begin
                    push          = 1'b1;
                    mask_next     = '0;
                    count_next    = '0;
                    complete_next = 1'b0;
                    state_next    = nsog_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nsog_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == nsog_pkg::ALGO_W'($countones(mask_reg)))
        else $error("distinct count out of step with seen mask");

    a_nib_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nsog_pkg::ST_NIB) |-> ({1'b0, rem_reg} < n_eff))
        else $error("nibble not fully reduced");

    a_fill_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nsog_pkg::ST_FILL) |-> (missing != '0))
        else $error("fill walk with nothing missing");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> slot_free)
        else $error("result pushed into a full output register");
`endif

endmodule

[sv/nibble_seed_order_generator.sv]
// Top level of the nibble seed order generator: APB register, sequencer, output register.
// Depends on nsog_pkg, nsog_apb, nsog_core, nsog_outbuf.
//
// Seed bytes enter on s_* (byte 31 first, s_tlast on the final byte); order digits leave on
// m_* with m_tuser = 1 for a digit and 0 for a terminator, m_tlast closing each seed's order.
// One byte at a time is in flight: s_tready is high only while the sequencer is idle. Each
// byte's nibbles h and l are reduced, high nibble first, modulo n, the effective count, by
// repeated subtraction in one shared compare/subtract unit. On the final byte of a seed
// whose order is still open, the missing-value walk steps over at most 16 indices, one index
// per cycle while the output register has room, or sends an empty-fill terminator.
// Back-pressure on m_tready stalls the sequencer whenever a result is due.
`timescale 1ns / 1ps

module nibble_seed_order_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nsog_pkg::APB_AW-1:0]       paddr,
    input  logic [nsog_pkg::APB_DW-1:0]       pwdata,
    output logic [nsog_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // seed byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] seed_byte
    input  logic                              s_tlast,   // seed_last
    // order stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [3:0] order_digit, [7:4] zero
    output logic                              m_tuser,   // [0] digit_valid
    output logic                              m_tlast    // order_end
);

    logic [nsog_pkg::ALGO_W-1:0] algo_count;
    logic                        slot_free;
    logic                        push;
    nsog_pkg::res_t              res;

    nsog_apb u_apb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .algo_count (algo_count)
    );

    nsog_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .algo_count (algo_count),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .slot_free  (slot_free),
        .push       (push),
        .res        (res)
    );

    nsog_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .res_in    (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
